@@ hw/rtl/byte_ring_queue_block_ops_assert.svh @@
// Assertion macros used by the checker file brq_check.sv.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BYTE_RING_QUEUE_BLOCK_OPS_ASSERT_SVH
`define BYTE_RING_QUEUE_BLOCK_OPS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BRQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brq assertion failed");

// Next-cycle implication, disabled during reset.
`define BRQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brq assertion failed");

`endif

@@ hw/rtl/brq_pkg.sv @@
// ---------------------------------------------------------------------------
// brq_pkg
// Shared types and constants of the byte ring queue.
// ---------------------------------------------------------------------------
`default_nettype none

package brq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int RUN_MAX       = 63;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ    = 2'd0,
        OP_READ   = 2'd1,
        OP_DEQ    = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/brq_if.sv @@
// ---------------------------------------------------------------------------
// brq_req_if / brq_rsp_if
// Valid/ready channels for requests into and results out of the queue.
// ---------------------------------------------------------------------------
`default_nettype none

interface brq_req_if;
    import brq_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  offset;
    logic              remove;
    logic [LEN_W-1:0]  position;
    logic              block_last;

    modport source (output valid, operation, data_byte, length, offset, remove,
                    position, block_last, input ready);
    modport sink   (input valid, operation, data_byte, length, offset, remove,
                    position, block_last, output ready);
endinterface

interface brq_rsp_if;
    import brq_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte_res;
    logic [STAT_W-1:0] status;
    logic              run_last;
    logic [LEN_W-1:0]  run_length;
    logic [LEN_W-1:0]  stored_count;
    logic [LEN_W-1:0]  free_count;

    modport source (output valid, data_byte_res, status, run_last, run_length,
                    stored_count, free_count, input ready);
    modport sink   (input valid, data_byte_res, status, run_last, run_length,
                    stored_count, free_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/brq_ram.sv @@
// ---------------------------------------------------------------------------
// brq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module brq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/byte_ring_queue_block_ops.sv @@
// Enqueue, status and refused requests give their one result in the cycle
// after the transfer; a read run gives its bytes one at a time, each by a RAM
// read, then an output load, and a stalled receiver holds the run back.
// Throughput: one single-result item per cycle while results are taken; a run
// holds off requests until its last byte is loaded. No clearing pass: the queue
// is usable right after rst_n releases, with the store empty.
// ---------------------------------------------------------------------------
// byte_ring_queue_block_ops
// Byte ring queue with block enqueue, peek/remove runs, dequeue-through and
// status, sequenced one result at a time over a shared slot stepper.
// ---------------------------------------------------------------------------
`default_nettype none

module byte_ring_queue_block_ops #(
    parameter int DEPTH = brq_pkg::DEPTH_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    brq_req_if.sink   req,
    brq_rsp_if.source rsp
);
    import brq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int WW = ((AW > LEN_W) ? AW : LEN_W) + 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] ws_reg, ws_next;
    logic [AW-1:0] sbo_reg, sbo_next;
    logic [AW-1:0] count_reg, count_next;
    logic in_block_reg, in_block_next;
    logic rej_reg, rej_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [LEN_W-1:0] size_reg, size_next;

    logic              ov_reg, ov_next;
    logic [BYTE_W-1:0] od_reg, od_next;
    status_t           ost_reg, ost_next;
    logic              olast_reg, olast_next;
    logic [LEN_W-1:0]  olen_reg, olen_next;
    logic [LEN_W-1:0]  ocnt_reg, ocnt_next;
    logic [LEN_W-1:0]  ofree_reg, ofree_next;

    logic              out_free;
    logic              accept;
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    function automatic logic [AW-1:0] wrap_add(input logic [WW-1:0] a,
                                               input logic [WW-1:0] b);
        logic [WW-1:0] s;
        s = a + b;
        if (s >= WW'(DEPTH))
        begin
            s = s - WW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] sat6(input logic [WW-1:0] v);
        return (v > WW'(RUN_MAX)) ? LEN_W'(RUN_MAX) : v[LEN_W-1:0];
    endfunction

    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign rsp.valid         = ov_reg;
    assign rsp.data_byte_res = od_reg;
    assign rsp.status        = ost_reg;
    assign rsp.run_last      = olast_reg;
    assign rsp.run_length    = olen_reg;
    assign rsp.stored_count  = ocnt_reg;
    assign rsp.free_count    = ofree_reg;

    brq_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ws_reg),
        .wdata(req.data_byte),
        .re   (ram_re),
        .raddr(slot_reg),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        logic [WW-1:0] cnt_w;
        logic [WW-1:0] free_w;
        logic [WW-1:0] len_w;
        logic [WW-1:0] off_w;
        logic [WW-1:0] size_w;
        logic [WW-1:0] pos_w;
        logic [WW-1:0] dist_w;
        logic [WW-1:0] after_w;
        logic          single;
        logic          run_go;
        logic          run_take;
        status_t       st;

        state_next    = state_reg;
        ws_next       = ws_reg;
        sbo_next      = sbo_reg;
        count_next    = count_reg;
        in_block_next = in_block_reg;
        rej_next      = rej_reg;
        slot_next     = slot_reg;
        remain_next   = remain_reg;
        size_next     = size_reg;
        ov_next       = ov_reg && !rsp.ready;
        od_next       = od_reg;
        ost_next      = ost_reg;
        olast_next    = olast_reg;
        olen_next     = olen_reg;
        ocnt_next     = ocnt_reg;
        ofree_next    = ofree_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        cnt_w    = WW'(count_reg);
        free_w   = WW'(DEPTH - 1) - cnt_w;
        len_w    = WW'(req.length);
        pos_w    = WW'(req.position);
        off_w    = '0;
        size_w   = '0;
        dist_w   = '0;
        after_w  = '0;
        single   = 1'b0;
        run_go   = 1'b0;
        run_take = 1'b0;
        st       = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(req.operation))
                        OP_ENQ:
                        begin
                            single = 1'b1;
                            if (!in_block_reg)
                            begin
                                if (len_w == '0)
                                begin
                                    rej_next = 1'b1;
                                    st       = ST_BAD;
                                end
                                else if (len_w > free_w)
                                begin
                                    rej_next = 1'b1;
                                    st       = ST_FULL;
                                end
                                else
                                begin
                                    rej_next = 1'b0;
                                end
                            end
                            else if (rej_reg)
                            begin
                                st = ST_FULL;
                            end
                            if (st == ST_OK)
                            begin
                                if (free_w == '0)
                                begin
                                    // overlong block: drop the byte
                                    st = ST_FULL;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    ws_next    = wrap_add(WW'(ws_reg), WW'(1));
                                    count_next = count_reg + AW'(1);
                                end
                            end
                            in_block_next = !req.block_last;
                            if (req.block_last)
                            begin
                                rej_next = 1'b0;
                            end
                        end
                        OP_READ:
                        begin
                            size_w = (len_w == '0) ? cnt_w : len_w;
                            if (size_w > WW'(RUN_MAX))
                            begin
                                size_w = WW'(RUN_MAX);
                            end
                            off_w = req.remove ? '0 : WW'(req.offset);
                            if (size_w == '0 || size_w + off_w > cnt_w)
                            begin
                                single = 1'b1;
                                st     = ST_BAD;
                            end
                            else
                            begin
                                run_go   = 1'b1;
                                run_take = req.remove;
                            end
                        end
                        OP_DEQ:
                        begin
                            if (pos_w >= WW'(DEPTH))
                            begin
                                single = 1'b1;
                                st     = ST_BAD;
                            end
                            else
                            begin
                                dist_w = pos_w + WW'(DEPTH) - WW'(sbo_reg);
                                if (dist_w >= WW'(DEPTH))
                                begin
                                    dist_w = dist_w - WW'(DEPTH);
                                end
                                if (dist_w == '0 || dist_w > cnt_w
                                    || dist_w > WW'(RUN_MAX))
                                begin
                                    single = 1'b1;
                                    st     = ST_BAD;
                                end
                                else
                                begin
                                    size_w   = dist_w;
                                    run_go   = 1'b1;
                                    run_take = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            single = 1'b1;
                        end
                    endcase

                    if (run_go)
                    begin
                        // first byte sits one slot past slot_before_oldest
                        slot_next = wrap_add(WW'(wrap_add(WW'(sbo_reg), WW'(1))), off_w);
                        remain_next = size_w[LEN_W-1:0];
                        size_next   = size_w[LEN_W-1:0];
                        state_next  = S_RD;
                        if (run_take)
                        begin
                            sbo_next   = wrap_add(WW'(sbo_reg), size_w);
                            count_next = count_reg - size_w[AW-1:0];
                        end
                    end

                    if (single)
                    begin
                        after_w    = WW'(count_next);
                        ov_next    = 1'b1;
                        od_next    = '0;
                        ost_next   = st;
                        olast_next = 1'b1;
                        olen_next  = '0;
                        ocnt_next  = sat6(after_w);
                        ofree_next = sat6(WW'(DEPTH - 1) - after_w);
                    end
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    od_next    = ram_rdata;
                    ost_next   = ST_OK;
                    olast_next = (remain_reg == LEN_W'(1));
                    olen_next  = size_reg;
                    ocnt_next  = sat6(cnt_w);
                    ofree_next = sat6(free_w);
                    if (remain_reg == LEN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // advance to the next slot
                        slot_next   = wrap_add(WW'(slot_reg), WW'(1));
                        remain_next = remain_reg - LEN_W'(1);
                        state_next  = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ws_reg       <= '0;
            sbo_reg      <= AW'(DEPTH - 1);
            count_reg    <= '0;
            in_block_reg <= 1'b0;
            rej_reg      <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ws_reg       <= ws_next;
            sbo_reg      <= sbo_next;
            count_reg    <= count_next;
            in_block_reg <= in_block_next;
            rej_reg      <= rej_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        remain_reg <= remain_next;
        size_reg   <= size_next;
        od_reg     <= od_next;
        ost_reg    <= ost_next;
        olast_reg  <= olast_next;
        olen_reg   <= olen_next;
        ocnt_reg   <= ocnt_next;
        ofree_reg  <= ofree_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/brq_check.sv @@
// ---------------------------------------------------------------------------
// brq_check
// Port-level checks of the byte ring queue, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "byte_ring_queue_block_ops_assert.svh"

module brq_check (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      req_valid,
    input wire logic                      req_ready,
    input wire logic [brq_pkg::OP_W-1:0]  req_operation,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic [brq_pkg::BYTE_W-1:0] rsp_data_byte_res,
    input wire logic [brq_pkg::STAT_W-1:0] rsp_status,
    input wire logic                      rsp_run_last,
    input wire logic [brq_pkg::LEN_W-1:0] rsp_run_length
);
    import brq_pkg::*;

    logic req_xfer;
    assign req_xfer = req_valid && req_ready;

    // hold a stalled result
    `BRQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_data_byte_res) && $stable(rsp_status))

    // a status query answers on the next cycle with a single ok result
    `BRQ_ASSERT_NXT(a_status_next, req_xfer && req_operation == OP_STATUS,
        rsp_valid && rsp_run_last && rsp_status == ST_OK && rsp_run_length == '0)

    // an error result stands alone and carries no byte
    `BRQ_ASSERT_IMP(a_err_alone, rsp_valid && rsp_status != ST_OK,
        rsp_run_last && rsp_run_length == '0 && rsp_data_byte_res == '0)

    // a result before the end of a run belongs to a nonempty ok run
    `BRQ_ASSERT_IMP(a_mid_run, rsp_valid && !rsp_run_last,
        rsp_status == ST_OK && rsp_run_length != '0)

endmodule

bind byte_ring_queue_block_ops brq_check u_brq_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_operation    (req.operation),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_data_byte_res(rsp.data_byte_res),
    .rsp_status       (rsp.status),
    .rsp_run_last     (rsp.run_last),
    .rsp_run_length   (rsp.run_length)
);

`default_nettype wire

@@ tb/tb_byte_ring_queue_block_ops.sv @@
// ---------------------------------------------------------------------------
// tb_byte_ring_queue_block_ops
// Self-checking bench for the byte ring queue. A directed table walks the
// empty, partly filled and rejected-block cases, then random block enqueues,
// peek/remove runs, dequeue-through and status requests follow. Every result
// transfer is compared field by field against a cycle-free queue predictor.
// ---------------------------------------------------------------------------
module tb_byte_ring_queue_block_ops;
    import brq_pkg::*;

    localparam int DEPTH          = DEPTH_DEFAULT;
    localparam int AW             = $clog2(DEPTH);
    localparam int N_DIRECTED     = 25;
    localparam int RANDOM_ITEMS   = 85;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int END_WAIT       = 20;

    typedef struct packed {
        op_t               operation;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  offset;
        logic              remove;
        logic [LEN_W-1:0]  position;
        logic              block_last;
    } req_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte_res;
        status_t           status;
        logic              run_last;
        logic [LEN_W-1:0]  run_length;
        logic [LEN_W-1:0]  stored_count;
        logic [LEN_W-1:0]  free_count;
    } rsp_item_t;

    typedef struct {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  off;
        logic              rem;
        logic [LEN_W-1:0]  pos;
        logic              last;
        bit                typed;
        status_t           exp_status;
        logic [LEN_W-1:0]  exp_stored;
        logic [LEN_W-1:0]  exp_free;
    } dir_row_t;

    // Single-result rows carry their result; the rest go through the predictor.
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{OP_STATUS, 8'h00,  6'd0,  6'd0, 1'b0,  6'd0, 1'b0, 1'b1, ST_OK,   6'd0, 6'd63},
        '{OP_READ,   8'h00,  6'd0,  6'd0, 1'b0,  6'd0, 1'b0, 1'b1, ST_BAD,  6'd0, 6'd63},
        '{OP_DEQ,    8'h00,  6'd0,  6'd0, 1'b0,  6'd5, 1'b0, 1'b1, ST_BAD,  6'd0, 6'd63},
        '{OP_ENQ,    8'h11,  6'd0,  6'd0, 1'b0,  6'd0, 1'b0, 1'b1, ST_BAD,  6'd0, 6'd63},
        '{OP_ENQ,    8'h22,  6'd5,  6'd0, 1'b0,  6'd0, 1'b1, 1'b1, ST_FULL, 6'd0, 6'd63},
        '{OP_ENQ,    8'h00,  6'd3,  6'd0, 1'b0,  6'd0, 1'b0, 1'b1, ST_OK,   6'd1, 6'd62},
        '{OP_ENQ,    8'hFF, 6'd63,  6'd0, 1'b0,  6'd0, 1'b0, 1'b1, ST_OK,   6'd2, 6'd61},
        '{OP_ENQ,    8'hA5,  6'd0,  6'd0, 1'b0,  6'd0, 1'b1, 1'b1, ST_OK,   6'd3, 6'd60},
        '{OP_STATUS, 8'h00,  6'd0,  6'd0, 1'b0,  6'd0, 1'b0, 1'b1, ST_OK,   6'd3, 6'd60},
        '{OP_READ,   8'h00,  6'd0,  6'd0, 1'b0,  6'd0, 1'b0, 1'b0, ST_OK,   6'd0, 6'd0},
        '{OP_READ,   8'h00,  6'd2,  6'd1, 1'b0,  6'd0, 1'b0, 1'b0, ST_OK,   6'd0, 6'd0},
        '{OP_READ,   8'h00,  6'd1,  6'd3, 1'b0,  6'd0, 1'b0, 1'b1, ST_BAD,  6'd3, 6'd60},
        '{OP_READ,   8'h00, 6'd63, 6'd63, 1'b0, 6'd63, 1'b1, 1'b1, ST_BAD,  6'd3, 6'd60},
        '{OP_ENQ,    8'h5A, 6'd61,  6'd0, 1'b0,  6'd0, 1'b0, 1'b1, ST_FULL, 6'd3, 6'd60},
        '{OP_ENQ,    8'hC3,  6'd0,  6'd0, 1'b0,  6'd0, 1'b1, 1'b1, ST_FULL, 6'd3, 6'd60},
        '{OP_ENQ,    8'h01,  6'd2,  6'd0, 1'b0,  6'd0, 1'b0, 1'b1, ST_OK,   6'd4, 6'd59},
        '{OP_STATUS, 8'h00,  6'd0,  6'd0, 1'b0,  6'd0, 1'b0, 1'b1, ST_OK,   6'd4, 6'd59},
        '{OP_READ,   8'h00,  6'd1,  6'd3, 1'b0,  6'd0, 1'b0, 1'b0, ST_OK,   6'd0, 6'd0},
        '{OP_ENQ,    8'h80, 6'd63,  6'd0, 1'b0,  6'd0, 1'b1, 1'b1, ST_OK,   6'd5, 6'd58},
        '{OP_READ,   8'h00,  6'd1, 6'd45, 1'b1,  6'd0, 1'b0, 1'b0, ST_OK,   6'd0, 6'd0},
        '{OP_DEQ,    8'h00,  6'd0,  6'd0, 1'b0,  6'd2, 1'b0, 1'b0, ST_OK,   6'd0, 6'd0},
        '{OP_DEQ,    8'h00,  6'd0,  6'd0, 1'b0, 6'd63, 1'b0, 1'b1, ST_BAD,  6'd2, 6'd61},
        '{OP_DEQ,    8'h00,  6'd0,  6'd0, 1'b0,  6'd2, 1'b0, 1'b1, ST_BAD,  6'd2, 6'd61},
        '{OP_READ,   8'h00,  6'd0, 6'd63, 1'b1,  6'd0, 1'b0, 1'b0, ST_OK,   6'd0, 6'd0},
        '{OP_ENQ,    8'h7E, 6'd63,  6'd0, 1'b0,  6'd0, 1'b1, 1'b1, ST_OK,   6'd1, 6'd62}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    brq_req_if req_ch ();
    brq_rsp_if rsp_ch ();

    byte_ring_queue_block_ops u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    // Queue predictor state
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    int unsigned       wr_slot;
    int unsigned       pre_head_slot;
    bit                in_blk;
    bit                blk_dropped;

    rsp_item_t   pending_results [$];
    rsp_item_t   head_res;
    int unsigned n_errors;
    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned stall_cycles;
    bit          hold_req;
    bit          drain_mode;
    logic [15:0] stall_pattern;
    logic [3:0]  pat_idx;

    function automatic int unsigned stored_bytes();
        return (wr_slot + DEPTH - 1 - pre_head_slot) % DEPTH;
    endfunction

    function automatic int unsigned free_bytes();
        return DEPTH - 1 - stored_bytes();
    endfunction

    function automatic rsp_item_t make_res(logic [BYTE_W-1:0] data, status_t st,
                                           logic last, int unsigned run_len);
        rsp_item_t r;
        r.data_byte_res = data;
        r.status        = st;
        r.run_last      = last;
        r.run_length    = run_len[LEN_W-1:0];
        r.stored_count  = LEN_W'((stored_bytes() > RUN_MAX) ? RUN_MAX : stored_bytes());
        r.free_count    = LEN_W'((free_bytes() > RUN_MAX) ? RUN_MAX : free_bytes());
        return r;
    endfunction

    // Emit size bytes from off past the oldest; the counts reflect the removal.
    function automatic void emit_bytes(int unsigned off, int unsigned size, bit take,
                                       ref rsp_item_t res[$]);
        int unsigned first_slot;
        first_slot = (pre_head_slot + 1) % DEPTH;
        if (take)
            pre_head_slot = (pre_head_slot + size) % DEPTH;
        for (int unsigned k = 0; k < size; k++)
            res.push_back(make_res(ring_mem[AW'((first_slot + off + k) % DEPTH)], ST_OK,
                                   k + 1 == size, size));
    endfunction

    function automatic void queue_predict(req_item_t it, ref rsp_item_t res[$]);
        status_t     st;
        int unsigned size;
        int unsigned off;
        int unsigned held;
        held = stored_bytes();
        res.delete();
        case (it.operation)
            OP_ENQ:
            begin
                if (!in_blk) begin
                    if (it.length == 0) begin
                        blk_dropped = 1'b1;
                        st = ST_BAD;
                    end else if (it.length > free_bytes()) begin
                        blk_dropped = 1'b1;
                        st = ST_FULL;
                    end else begin
                        blk_dropped = 1'b0;
                        st = ST_OK;
                    end
                end else begin
                    st = blk_dropped ? ST_FULL : ST_OK;
                end
                if (st == ST_OK) begin
                    if (free_bytes() == 0) begin
                        st = ST_FULL;
                    end else begin
                        ring_mem[AW'(wr_slot)] = it.data_byte;
                        wr_slot = (wr_slot + 1) % DEPTH;
                    end
                end
                in_blk = !it.block_last;
                if (it.block_last)
                    blk_dropped = 1'b0;
                res.push_back(make_res('0, st, 1'b1, 0));
            end
            OP_READ:
            begin
                size = (it.length == 0) ? held : it.length;
                off  = it.remove ? 0 : it.offset;
                if (size > RUN_MAX)
                    size = RUN_MAX;
                if (size == 0 || size + off > held)
                    res.push_back(make_res('0, ST_BAD, 1'b1, 0));
                else
                    emit_bytes(off, size, it.remove, res);
            end
            OP_DEQ:
            begin
                size = (it.position + DEPTH - pre_head_slot) % DEPTH;
                if (it.position >= DEPTH || size == 0 || size > held || size > RUN_MAX)
                    res.push_back(make_res('0, ST_BAD, 1'b1, 0));
                else
                    emit_bytes(0, size, 1'b1, res);
            end
            default:
            begin
                res.push_back(make_res('0, ST_OK, 1'b1, 0));
            end
        endcase
    endfunction

    function automatic req_item_t noise_item();
        req_item_t it;
        it.operation  = op_t'($urandom_range(0, 3));
        it.data_byte  = BYTE_W'($urandom_range(0, 255));
        it.length     = LEN_W'($urandom_range(0, 63));
        it.offset     = LEN_W'($urandom_range(0, 63));
        it.remove     = 1'($urandom_range(0, 1));
        it.position   = LEN_W'($urandom_range(0, 63));
        it.block_last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // Drop valid between bursts of random length.
    task automatic pace();
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
    endtask

    task automatic send_item(req_item_t it, bit use_typed, rsp_item_t typed_res);
        rsp_item_t res [$];
        pace();
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= it.operation;
        req_ch.data_byte  <= it.data_byte;
        req_ch.length     <= it.length;
        req_ch.offset     <= it.offset;
        req_ch.remove     <= it.remove;
        req_ch.position   <= it.position;
        req_ch.block_last <= it.block_last;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        queue_predict(it, res);
        if (use_typed)
            pending_results.push_back(typed_res);
        else
            foreach (res[i])
                pending_results.push_back(res[i]);
        items_sent++;
    endtask

    // One enqueue block: mostly fitting, sometimes empty, oversized, overlong
    // or left open, with an occasional other request slipped in between bytes.
    task automatic send_block();
        int unsigned room;
        int unsigned blk_len;
        int unsigned n_bytes;
        bit          open_end;
        req_item_t   it;
        room = free_bytes();
        case ($urandom_range(0, 9))
            0: blk_len = 0;
            1: blk_len = $urandom_range(0, 63);
            2: blk_len = (room < 63) ? room + 1 : 63;
            3: blk_len = (room <= 30) ? ((room == 0) ? 1 : room) : $urandom_range(8, 20);
            default: blk_len = (room == 0) ? 1 : $urandom_range(1, (room < 6) ? room : 6);
        endcase
        n_bytes = (blk_len == 0) ? $urandom_range(1, 3) : blk_len;
        if ($urandom_range(0, 9) == 0)
            n_bytes += $urandom_range(1, 3);
        open_end = ($urandom_range(0, 19) == 0);
        // stop early once the item budget is spent; the block is left open
        for (int unsigned i = 0; i < n_bytes && items_sent < N_DIRECTED + RANDOM_ITEMS;
             i++) begin
            it = noise_item();
            it.operation = OP_ENQ;
            if (i == 0)
                it.length = LEN_W'(blk_len);
            it.block_last = (i + 1 == n_bytes) && !open_end;
            send_item(it, 1'b0, '0);
            if ($urandom_range(0, 11) == 0) begin
                it = noise_item();
                if (it.operation == OP_ENQ)
                    it.operation = OP_STATUS;
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    // Result checker
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: byte %0d status %0d",
                       rsp_ch.data_byte_res, rsp_ch.status);
                n_errors++;
            end else begin
                head_res = pending_results.pop_front();
                check_field("data_byte_res", 32'(head_res.data_byte_res),
                            32'(rsp_ch.data_byte_res));
                check_field("status", 32'(head_res.status), 32'(rsp_ch.status));
                check_field("run_last", 32'(head_res.run_last), 32'(rsp_ch.run_last));
                check_field("run_length", 32'(head_res.run_length), 32'(rsp_ch.run_length));
                check_field("stored_count", 32'(head_res.stored_count),
                            32'(rsp_ch.stored_count));
                check_field("free_count", 32'(head_res.free_count), 32'(rsp_ch.free_count));
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("tb_byte_ring_queue_block_ops failed");
                $finish;
            end
        end
    end

    // Result receiver: stall on a rotating pattern, hold off on request
    initial begin
        rsp_ch.ready <= 1'b0;
        stall_pattern = 16'hFFFF;
        pat_idx       = '0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            if (drain_mode)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= stall_pattern[pat_idx];
            pat_idx++;
            if (pat_idx == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pattern = 16'hFFFF;
                    1: stall_pattern = 16'($urandom);
                    default: stall_pattern = 16'($urandom | $urandom);
                endcase
            end
        end
    end

    initial begin
        req_item_t   it;
        rsp_item_t   typed_res;
        int unsigned held;
        int unsigned pick;

        req_ch.valid      <= 1'b0;
        req_ch.operation  <= OP_ENQ;
        req_ch.data_byte  <= '0;
        req_ch.length     <= '0;
        req_ch.offset     <= '0;
        req_ch.remove     <= 1'b0;
        req_ch.position   <= '0;
        req_ch.block_last <= 1'b0;

        foreach (ring_mem[i])
            ring_mem[i] = '0;
        wr_slot       = 0;
        pre_head_slot = DEPTH - 1;
        in_blk        = 1'b0;
        blk_dropped   = 1'b0;
        n_errors      = 0;
        items_sent    = 0;
        burst_left    = 0;
        hold_req      = 1'b0;
        drain_mode    = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            it.operation  = directed_rows[i].op;
            it.data_byte  = directed_rows[i].data;
            it.length     = directed_rows[i].len;
            it.offset     = directed_rows[i].off;
            it.remove     = directed_rows[i].rem;
            it.position   = directed_rows[i].pos;
            it.block_last = directed_rows[i].last;
            typed_res.data_byte_res = '0;
            typed_res.status        = directed_rows[i].exp_status;
            typed_res.run_last      = 1'b1;
            typed_res.run_length    = '0;
            typed_res.stored_count  = directed_rows[i].exp_stored;
            typed_res.free_count    = directed_rows[i].exp_free;
            send_item(it, directed_rows[i].typed, typed_res);
        end

        // Hold off the receiver while a long burst keeps offering requests
        hold_req   = 1'b1;
        burst_left = 40;

        while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
            held = stored_bytes();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_block();
            end else begin
                it = noise_item();
                if (pick < 65) begin
                    it.operation = OP_READ;
                    if ($urandom_range(0, 4) != 0) begin
                        it.length = LEN_W'($urandom_range(0, (held + 1 > 63) ? 63 : held + 1));
                        it.offset = LEN_W'($urandom_range(0, 3));
                    end
                end else if (pick < 80) begin
                    it.operation = OP_DEQ;
                    if ($urandom_range(0, 4) != 0)
                        it.position = LEN_W'((pre_head_slot + $urandom_range(0, held + 1))
                                             % DEPTH);
                end else if (pick < 88) begin
                    it.operation = OP_STATUS;
                end
                send_item(it, 1'b0, '0);
            end
        end
        req_ch.valid <= 1'b0;
        drain_mode = 1'b1;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        if (n_errors == 0)
            $display("tb_byte_ring_queue_block_ops passed");
        else
            $display("tb_byte_ring_queue_block_ops failed");
        $finish;
    end

endmodule

@@ byte_ring_queue_block_ops.f @@
+incdir+hw/rtl
hw/rtl/brq_pkg.sv
hw/rtl/brq_if.sv
hw/rtl/brq_ram.sv
hw/rtl/byte_ring_queue_block_ops.sv
hw/rtl/brq_check.sv
tb/tb_byte_ring_queue_block_ops.sv
